// ===== hdl/opee_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opee_pkg
// Shared types and constants of the object path escape encoder.
// ----------------------------------------------------------------------------
package opee_pkg;

  // Width of a decoded code point.
  localparam int unsigned CP_W   = 21;
  // Width of a hex digit count (1..6).
  localparam int unsigned NDIG_W = 3;

  // Command queue between the decoder and the emitter.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Escape delimiter.
  localparam logic [7:0] CHAR_US = 8'h5F;

  typedef enum logic [1:0] {
    KIND_PLAIN  = 2'd0,  // one byte, passed through
    KIND_ESCAPE = 2'd1,  // '_', hex digits, '_'
    KIND_BAD    = 2'd2   // bad-input marker
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CP_W-1:0]   code;
    logic [NDIG_W-1:0] ndig;
    logic              eos;
  } entry_t;

  // Lowercase hex character of one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'b0, nib};
    end else begin
      c = 8'h57 + {4'b0, nib};
    end
    return c;
  endfunction

endpackage

// ===== hdl/opee_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opee_front
// UTF-8 decoder: takes source bytes, checks them and pushes one command per
// completed code point, error or string close into the queue.
// ----------------------------------------------------------------------------
module opee_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 end_of_string_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output opee_pkg::entry_t     push_entry_o
);

  // Range rule for the next continuation byte.
  localparam logic [2:0] RULE_ANY = 3'd0;  // 80..BF
  localparam logic [2:0] RULE_E0  = 3'd1;  // A0..BF
  localparam logic [2:0] RULE_ED  = 3'd2;  // 80..9F
  localparam logic [2:0] RULE_F0  = 3'd3;  // 90..BF
  localparam logic [2:0] RULE_F4  = 3'd4;  // 80..8F

  logic [opee_pkg::CP_W-1:0] acc_q, acc_d;
  logic [1:0]                left_q, left_d;
  logic [2:0]                rule_q, rule_d;
  logic                      err_q, err_d;

  logic                      accept;
  logic                      bad, have;
  logic [opee_pkg::CP_W-1:0] cp;
  logic [opee_pkg::CP_W-1:0] acc_next;
  logic [7:0]                lo, hi;
  logic [7:0]                b;

  function automatic logic is_plain(input logic [opee_pkg::CP_W-1:0] c);
    logic r;
    r = 1'b0;
    if (c[opee_pkg::CP_W-1:7] == '0) begin
      r = (c[6:0] >= 7'h61 && c[6:0] <= 7'h7A) ||
          (c[6:0] >= 7'h41 && c[6:0] <= 7'h5A) ||
          (c[6:0] >= 7'h30 && c[6:0] <= 7'h39) ||
          (c[6:0] == 7'h2F);
    end
    return r;
  endfunction

  function automatic logic [opee_pkg::NDIG_W-1:0] digit_count(
    input logic [opee_pkg::CP_W-1:0] c);
    logic [opee_pkg::NDIG_W-1:0] n;
    if (c[20]) begin
      n = 3'd6;
    end else if (|c[19:16]) begin
      n = 3'd5;
    end else if (|c[15:12]) begin
      n = 3'd4;
    end else if (|c[11:8]) begin
      n = 3'd3;
    end else if (|c[7:4]) begin
      n = 3'd2;
    end else begin
      n = 3'd1;
    end
    return n;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_byte_i;
  assign acc_next   = {acc_q[opee_pkg::CP_W-7:0], b[5:0]};

  always_comb begin
    lo = 8'h80;
    hi = 8'hBF;
    unique case (rule_q)
      RULE_E0: lo = 8'hA0;
      RULE_ED: hi = 8'h9F;
      RULE_F0: lo = 8'h90;
      RULE_F4: hi = 8'h8F;
      default: ;
    endcase
  end

  always_comb begin
    acc_d        = acc_q;
    left_d       = left_q;
    rule_d       = rule_q;
    err_d        = err_q;
    bad          = 1'b0;
    have         = 1'b0;
    cp           = '0;
    push_o       = 1'b0;
    push_entry_o = '0;

    if (accept) begin
      if (err_q) begin
        // Discard until the end marker, then close the string.
        if (end_of_string_i) begin
          err_d                 = 1'b0;
          push_o                = 1'b1;
          push_entry_o.kind     = opee_pkg::KIND_BAD;
          push_entry_o.eos      = 1'b1;
        end
      end else begin
        if (left_q == 2'd0) begin
          if (b == 8'h00) begin
            bad = 1'b1;
          end else if (b < 8'h80) begin
            cp   = {13'b0, b};
            have = 1'b1;
          end else if (b < 8'hC2) begin
            bad = 1'b1;
          end else if (b < 8'hE0) begin
            acc_d  = {16'b0, b[4:0]};
            left_d = 2'd1;
            rule_d = RULE_ANY;
          end else if (b < 8'hF0) begin
            acc_d  = {17'b0, b[3:0]};
            left_d = 2'd2;
            rule_d = (b == 8'hE0) ? RULE_E0 : (b == 8'hED) ? RULE_ED : RULE_ANY;
          end else if (b < 8'hF5) begin
            acc_d  = {18'b0, b[2:0]};
            left_d = 2'd3;
            rule_d = (b == 8'hF0) ? RULE_F0 : (b == 8'hF4) ? RULE_F4 : RULE_ANY;
          end else begin
            bad = 1'b1;
          end
        end else begin
          if (b < lo || b > hi) begin
            bad = 1'b1;
          end else begin
            acc_d  = acc_next;
            rule_d = RULE_ANY;
            left_d = left_q - 2'd1;
            if (left_q == 2'd1) begin
              cp   = acc_next;
              have = 1'b1;
            end
          end
        end

        // Sequence cut short by the end marker.
        if (!bad && !have && end_of_string_i) begin
          bad = 1'b1;
        end

        if (bad) begin
          acc_d             = '0;
          left_d            = 2'd0;
          rule_d            = RULE_ANY;
          err_d             = !end_of_string_i;
          push_o            = 1'b1;
          push_entry_o.kind = opee_pkg::KIND_BAD;
          push_entry_o.eos  = end_of_string_i;
        end else if (have) begin
          acc_d             = '0;
          push_o            = 1'b1;
          push_entry_o.kind = is_plain(cp) ? opee_pkg::KIND_PLAIN : opee_pkg::KIND_ESCAPE;
          push_entry_o.code = cp;
          push_entry_o.ndig = digit_count(cp);
          push_entry_o.eos  = end_of_string_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      left_q <= 2'd0;
      rule_q <= RULE_ANY;
      err_q  <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      left_q <= left_d;
      rule_q <= rule_d;
      err_q  <= err_d;
    end
  end

endmodule

// ===== hdl/opee_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opee_queue
// Short command queue that decouples the decoder from the emitter.
// ----------------------------------------------------------------------------
module opee_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  opee_pkg::entry_t push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output opee_pkg::entry_t head_entry_o
);

  opee_pkg::entry_t                slot_q [opee_pkg::QDEPTH];
  logic [opee_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [opee_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [opee_pkg::QCNT_W-1:0]     cnt_q, cnt_d;

  function automatic logic [opee_pkg::QPTR_W-1:0] ptr_inc(
    input logic [opee_pkg::QPTR_W-1:0] p);
    logic [opee_pkg::QPTR_W-1:0] r;
    if (p == opee_pkg::QPTR_W'(opee_pkg::QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full_o       = (cnt_q == opee_pkg::QCNT_W'(opee_pkg::QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== hdl/opee_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opee_back
// Emitter: expands the queue head into output bytes, one per cycle while the
// output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module opee_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  opee_pkg::entry_t head_entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             string_done_o,
  output logic             bad_input_o
);

  logic [2:0]                  idx_q, idx_d;
  logic                        out_valid_q, out_valid_d;
  logic [7:0]                  byte_q;
  logic                        last_q, done_q, bad_q;

  logic                        out_load;
  logic                        emit;
  logic [7:0]                  nxt_byte;
  logic                        nxt_last;
  logic                        nxt_bad;
  logic [opee_pkg::NDIG_W-1:0] sel;
  logic [3:0]                  nib;

  assign out_load = !out_valid_q || out_ready_i;
  assign emit     = head_valid_i && out_load;
  assign sel      = head_entry_i.ndig - idx_q;

  always_comb begin
    case (sel)
      3'd0:    nib = head_entry_i.code[3:0];
      3'd1:    nib = head_entry_i.code[7:4];
      3'd2:    nib = head_entry_i.code[11:8];
      3'd3:    nib = head_entry_i.code[15:12];
      3'd4:    nib = head_entry_i.code[19:16];
      3'd5:    nib = {3'b0, head_entry_i.code[20]};
      default: nib = 4'h0;
    endcase
  end

  always_comb begin
    nxt_byte = 8'h00;
    nxt_last = 1'b1;
    nxt_bad  = 1'b0;
    unique case (head_entry_i.kind)
      opee_pkg::KIND_PLAIN: begin
        nxt_byte = head_entry_i.code[7:0];
      end
      opee_pkg::KIND_ESCAPE: begin
        // '_' first and last, hex digits between, most significant first.
        if (idx_q == 3'd0) begin
          nxt_byte = opee_pkg::CHAR_US;
          nxt_last = 1'b0;
        end else if (idx_q == head_entry_i.ndig + 3'd1) begin
          nxt_byte = opee_pkg::CHAR_US;
        end else begin
          nxt_byte = opee_pkg::hex_char(nib);
          nxt_last = 1'b0;
        end
      end
      default: begin
        nxt_bad = 1'b1;
      end
    endcase
  end

  assign pop_o = emit && nxt_last;

  always_comb begin
    idx_d = idx_q;
    if (emit) begin
      idx_d = nxt_last ? 3'd0 : idx_q + 3'd1;
    end
    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= nxt_byte;
      last_q <= nxt_last;
      done_q <= nxt_last && head_entry_i.eos;
      bad_q  <= nxt_bad;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = byte_q;
  assign run_last_o    = last_q;
  assign string_done_o = done_q;
  assign bad_input_o   = bad_q;

endmodule

// ===== hdl/object_path_escape_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// object_path_escape_encoder_core
// Escapes a UTF-8 string, byte by byte, into an ASCII object path.
// ----------------------------------------------------------------------------
// Feed the UTF-8 string one byte per transaction, with end_of_string_i high on
// its last byte. Letters, digits and '/' come out unchanged; any other code
// point comes out as '_', its lowercase hex value without leading zeros, and
// '_' (3 to 8 bytes). run_last_o marks the last byte caused by an input byte
// and string_done_o the last byte of the string. Invalid UTF-8 (zero byte,
// overlong form, surrogate, value above 10FFFF, stray or missing continuation
// byte, sequence cut short by the end marker) gives one transaction with
// bad_input_o high and out_byte_o zero; the rest of the string is dropped
// and its end marker yields one more bad_input_o transaction with
// string_done_o high. Bytes already sent stay sent, so drop the whole string
// on bad_input_o. Rate: the decoder takes one byte per cycle while its
// two-entry command queue has room; the emitter writes one output byte per
// cycle while the output accepts, so a pass-through character gives one byte
// and an escape with n hex digits gives n+2 bytes, which sets the sustained
// rate on escape-heavy text. Input and output handshakes stall independently.
// ----------------------------------------------------------------------------
module object_path_escape_encoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_done_o,
  output logic       bad_input_o
);

  // Decoder to queue.
  logic             push;
  opee_pkg::entry_t push_entry;
  logic             q_full;
  // Queue to emitter.
  logic             pop;
  logic             head_valid;
  opee_pkg::entry_t head_entry;

  // Decode and check UTF-8, hold sequence state across bytes.
  opee_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_entry_o    (push_entry)
  );

  // Buffer commands so the decoder keeps going while an escape drains.
  opee_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry)
  );

  // Expand each command into output bytes.
  opee_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_entry_i  (head_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .string_done_o (string_done_o),
    .bad_input_o   (bad_input_o)
  );

endmodule

// ===== tb/sv/object_path_escape_encoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// object_path_escape_encoder_core_tb
// Self-checking bench for the UTF-8 to object path escape encoder.
// ----------------------------------------------------------------------------
// Drive UTF-8 strings into the encoder over its valid/ready input and predict,
// for every accepted input transaction, the escaped output bytes it causes.
// A monitor compares every accepted output transaction field by field with
// the oldest predicted byte. Stimulus opens with directed strings (pass-through
// characters, escape lengths from one to six hex digits, each kind of invalid
// UTF-8), then runs random text that is mostly well formed with some
// corruption and noise. Both sides idle at random; one phase runs with no
// idling, one holds the output off for a long stretch so the encoder fills up,
// and one pauses the input until all output has drained.
// ----------------------------------------------------------------------------
module object_path_escape_encoder_core_tb;

  localparam int unsigned CLK_PERIOD       = 10;
  localparam int unsigned RESET_CYCLES     = 4;
  localparam int unsigned ITEM_TARGET      = 430;
  localparam int unsigned IDLE_PCT         = 12;
  localparam int unsigned SINK_HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT      = 4000;
  localparam int unsigned TAIL_CYCLES      = 32;
  localparam int unsigned MAX_REPORTS      = 10;

  // ASCII characters that pass through unescaped, and the hex digit bases.
  localparam logic [7:0] ASC_SLASH = 8'h2F;
  localparam logic [7:0] ASC_ZERO  = 8'h30;
  localparam logic [7:0] ASC_NINE  = 8'h39;
  localparam logic [7:0] ASC_UP_A  = 8'h41;
  localparam logic [7:0] ASC_UP_Z  = 8'h5A;
  localparam logic [7:0] ASC_LO_A  = 8'h61;
  localparam logic [7:0] ASC_LO_Z  = 8'h7A;

  // Allowed range of the next continuation byte.
  typedef enum logic [2:0] {
    RULE_ANY      = 3'd0,  // 80..BF
    RULE_AFTER_E0 = 3'd1,  // A0..BF, rejects overlong 3-byte forms
    RULE_AFTER_ED = 3'd2,  // 80..9F, rejects surrogates
    RULE_AFTER_F0 = 3'd3,  // 90..BF, rejects overlong 4-byte forms
    RULE_AFTER_F4 = 3'd4   // 80..8F, rejects values above 10FFFF
  } cont_rule_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
    logic       bad_input;
  } path_byte_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input is known from time zero.
  // --------------------------------------------------------------------------
  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i       = 8'h00;
  logic       end_of_string_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i     = 1'b0;
  logic [7:0] out_byte_o;
  logic       run_last_o;
  logic       string_done_o;
  logic       bad_input_o;

  object_path_escape_encoder_core uut (.*);

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  path_byte_t  path_bytes_due[$];  // predicted output, oldest first
  logic [7:0]  utf8_buf[$];        // string being assembled for sending
  int unsigned bytes_sent    = 0;
  int unsigned mismatches    = 0;
  bit          calm          = 1'b0;  // no idling on either side
  bit          sink_hold_req = 1'b0;  // ask the sink for one long hold-off

  // Decoder state of the predictor.
  logic [20:0] pend_code  = '0;
  logic [1:0]  pend_conts = '0;
  cont_rule_e  pend_rule  = RULE_ANY;
  logic        dropping   = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void queue_path_byte(input logic [7:0] b, input logic last,
                                          input logic done, input logic bad);
    path_byte_t pb;
    pb.out_byte    = b;
    pb.run_last    = last;
    pb.string_done = done;
    pb.bad_input   = bad;
    path_bytes_due.push_back(pb);
  endfunction

  function automatic void clear_decoder();
    pend_code  = '0;
    pend_conts = '0;
    pend_rule  = RULE_ANY;
    dropping   = 1'b0;
  endfunction

  // Work out the output bytes caused by one accepted input byte.
  function automatic void predict_path_bytes(input logic [7:0] b, input logic eos);
    logic        bad;
    logic        have;
    logic [20:0] cp;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [3:0]  nib;
    int          digits;
    bad  = 1'b0;
    have = 1'b0;
    cp   = '0;
    lo   = 8'h80;
    hi   = 8'hBF;

    // Drop everything after an error; only the end marker closes the string.
    if (dropping) begin
      if (eos) begin
        clear_decoder();
        queue_path_byte(8'h00, 1'b1, 1'b1, 1'b1);
      end
      return;
    end

    if (pend_conts == 2'd0) begin
      if (b == 8'h00) begin
        bad = 1'b1;
      end else if (b < 8'h80) begin
        cp   = {13'b0, b};
        have = 1'b1;
      end else if (b < 8'hC2) begin
        bad = 1'b1;  // stray continuation, or overlong 2-byte lead
      end else if (b < 8'hE0) begin
        pend_code  = {16'b0, b[4:0]};
        pend_conts = 2'd1;
        pend_rule  = RULE_ANY;
      end else if (b < 8'hF0) begin
        pend_code  = {17'b0, b[3:0]};
        pend_conts = 2'd2;
        pend_rule  = (b == 8'hE0) ? RULE_AFTER_E0 :
                     (b == 8'hED) ? RULE_AFTER_ED : RULE_ANY;
      end else if (b < 8'hF5) begin
        pend_code  = {18'b0, b[2:0]};
        pend_conts = 2'd3;
        pend_rule  = (b == 8'hF0) ? RULE_AFTER_F0 :
                     (b == 8'hF4) ? RULE_AFTER_F4 : RULE_ANY;
      end else begin
        bad = 1'b1;
      end
    end else begin
      case (pend_rule)
        RULE_AFTER_E0: lo = 8'hA0;
        RULE_AFTER_ED: hi = 8'h9F;
        RULE_AFTER_F0: lo = 8'h90;
        RULE_AFTER_F4: hi = 8'h8F;
        default: ;
      endcase
      if (b < lo || b > hi) begin
        bad = 1'b1;
      end else begin
        pend_code  = {pend_code[14:0], b[5:0]};
        pend_rule  = RULE_ANY;
        pend_conts = pend_conts - 2'd1;
        if (pend_conts == 2'd0) begin
          cp   = pend_code;
          have = 1'b1;
        end
      end
    end

    // A sequence still open at the end marker counts as invalid.
    if (!bad && !have && eos) begin
      bad = 1'b1;
    end

    if (bad) begin
      clear_decoder();
      dropping = !eos;
      queue_path_byte(8'h00, 1'b1, eos, 1'b1);
      return;
    end

    if (have) begin
      pend_code = '0;
      if (eos) begin
        clear_decoder();
      end
      if ((cp >= {13'b0, ASC_LO_A} && cp <= {13'b0, ASC_LO_Z}) ||
          (cp >= {13'b0, ASC_UP_A} && cp <= {13'b0, ASC_UP_Z}) ||
          (cp >= {13'b0, ASC_ZERO} && cp <= {13'b0, ASC_NINE}) ||
          cp == {13'b0, ASC_SLASH}) begin
        queue_path_byte(cp[7:0], 1'b1, eos, 1'b0);
      end else begin
        // '_', hex without leading zeros, '_'
        digits = 1;
        while (digits < 6 && (cp >> (4 * digits)) != 21'd0) begin
          digits++;
        end
        queue_path_byte(opee_pkg::CHAR_US, 1'b0, 1'b0, 1'b0);
        for (int i = digits - 1; i >= 0; i--) begin
          nib = 4'(cp >> (4 * i));
          queue_path_byte((nib < 4'd10) ? ASC_ZERO + 8'(nib) : ASC_LO_A + 8'(nib) - 8'd10,
                          1'b0, 1'b0, 1'b0);
        end
        queue_path_byte(opee_pkg::CHAR_US, 1'b1, eos, 1'b0);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: predict on input transactions, then check output transactions.
  // Both run in this one process so their order within an edge is fixed.
  // --------------------------------------------------------------------------
  function automatic void flag_mismatch(input string what, input path_byte_t due,
                                        input path_byte_t seen);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t ns: %s: expected %02h/%b/%b/%b, got %02h/%b/%b/%b",
               $time, what, due.out_byte, due.run_last, due.string_done, due.bad_input,
               seen.out_byte, seen.run_last, seen.string_done, seen.bad_input);
    end
  endfunction

  always @(posedge clk_i) begin : path_monitor
    path_byte_t seen;
    path_byte_t due;
    if (in_valid_i && in_ready_o) begin
      predict_path_bytes(in_byte_i, end_of_string_i);
    end
    if (out_valid_o && out_ready_i) begin
      seen.out_byte    = out_byte_o;
      seen.run_last    = run_last_o;
      seen.string_done = string_done_o;
      seen.bad_input   = bad_input_o;
      if (path_bytes_due.size() == 0) begin
        flag_mismatch("unexpected output", '0, seen);
      end else begin
        due = path_bytes_due.pop_front();
        if (seen.out_byte !== due.out_byte || seen.run_last !== due.run_last ||
            seen.string_done !== due.string_done || seen.bad_input !== due.bad_input) begin
          flag_mismatch("output mismatch", due, seen);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves on either channel for too long.
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: watchdog, no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Output side: random stalls, a calm mode, and one long counted hold-off.
  // --------------------------------------------------------------------------
  initial begin : sink_control
    int unsigned held;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req) begin
        out_ready_i <= 1'b0;
        for (held = 1; held < SINK_HOLD_CYCLES; held++) begin
          @(posedge clk_i);
        end
        sink_hold_req = 1'b0;
      end else if (calm) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one byte and hold it until the encoder takes it. Valid stays high
  // afterwards; the next call either replaces the payload or drops valid.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_byte_i       <= b;
    end_of_string_i <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_utf8_buf();
    foreach (utf8_buf[i]) begin
      send_byte(utf8_buf[i], i == utf8_buf.size() - 1);
    end
  endtask

  // Drop valid and wait until every predicted byte has come out. The loop
  // always waits on the clock first so valid never gets two updates in one step.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (path_bytes_due.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Random text
  // --------------------------------------------------------------------------
  function automatic logic [20:0] random_code_point();
    int unsigned pick;
    logic [20:0] cp;
    pick = $urandom_range(99);
    if (pick < 35) begin
      case ($urandom_range(3))
        0:       cp = 21'(ASC_LO_A) + 21'($urandom_range(25));
        1:       cp = 21'(ASC_UP_A) + 21'($urandom_range(25));
        2:       cp = 21'(ASC_ZERO) + 21'($urandom_range(9));
        default: cp = 21'(ASC_SLASH);
      endcase
    end else if (pick < 50) begin
      cp = 21'($urandom_range(1, 'h7F));
    end else if (pick < 70) begin
      cp = 21'($urandom_range('h80, 'h7FF));
    end else if (pick < 85) begin
      cp = 21'($urandom_range('h800, 'hFFFF));
      // Step over the surrogate block.
      if (cp >= 21'h00D800 && cp <= 21'h00DFFF) begin
        cp = cp + 21'h000800;
      end
    end else begin
      cp = 21'($urandom_range('h10000, 'h10FFFF));
    end
    return cp;
  endfunction

  function automatic void append_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      utf8_buf.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      utf8_buf.push_back({3'b110, cp[10:6]});
      utf8_buf.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      utf8_buf.push_back({4'b1110, cp[15:12]});
      utf8_buf.push_back({2'b10, cp[11:6]});
      utf8_buf.push_back({2'b10, cp[5:0]});
    end else begin
      utf8_buf.push_back({5'b11110, cp[20:18]});
      utf8_buf.push_back({2'b10, cp[17:12]});
      utf8_buf.push_back({2'b10, cp[11:6]});
      utf8_buf.push_back({2'b10, cp[5:0]});
    end
  endfunction

  // Fill utf8_buf with one string: mostly well-formed text, sometimes with a
  // corrupted byte, a cut-off tail or an embedded zero, sometimes pure noise.
  function automatic void build_random_string();
    int unsigned n;
    utf8_buf.delete();
    if ($urandom_range(99) < 10) begin
      n = $urandom_range(1, 6);
      repeat (n) utf8_buf.push_back(8'($urandom_range(255)));
      return;
    end
    n = $urandom_range(1, 10);
    repeat (n) append_utf8(random_code_point());
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(2))
        0: utf8_buf[$urandom_range(utf8_buf.size() - 1)] = 8'($urandom_range(255));
        1: if (utf8_buf.size() > 1) utf8_buf.pop_back();
        default: utf8_buf.insert($urandom_range(utf8_buf.size() - 1), 8'h00);
      endcase
    end
  endfunction

  task automatic send_random_strings(input int unsigned count);
    int unsigned stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      build_random_string();
      send_utf8_buf();
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Pass-through edges, escapes of one to six hex digits, ending with the
  // largest code point (eight output bytes).
  task automatic test_passthrough_and_escapes();
    utf8_buf = '{ASC_SLASH, ASC_ZERO, ASC_NINE, ASC_UP_A, ASC_UP_Z, ASC_LO_A,
                 ASC_LO_Z, 8'h01, 8'h7F, 8'hDF, 8'hBF, 8'hE2, 8'h82, 8'hAC,
                 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_utf8_buf();
  endtask

  // One string per kind of invalid input.
  task automatic test_malformed_input();
    // zero byte at the start of a string, then the rest is dropped up to the end marker
    utf8_buf = '{8'h00, ASC_UP_A, ASC_LO_Z};
    send_utf8_buf();
    // stray continuation byte that is also the end marker
    utf8_buf = '{8'h80};
    send_utf8_buf();
    // byte that never starts a sequence
    utf8_buf = '{8'hFF};
    send_utf8_buf();
    // overlong 3-byte form
    utf8_buf = '{8'hE0, 8'h9F};
    send_utf8_buf();
    // surrogate
    utf8_buf = '{8'hED, 8'hA0};
    send_utf8_buf();
    // above 10FFFF
    utf8_buf = '{8'hF4, 8'h90};
    send_utf8_buf();
    // ASCII byte where a continuation byte belongs
    utf8_buf = '{8'hC2, ASC_UP_A};
    send_utf8_buf();
    // sequence cut short by the end marker
    utf8_buf = '{8'hE2, 8'h82};
    send_utf8_buf();
  endtask

  // Pause the input until every output byte has come, then go on.
  task automatic test_pause_until_drained();
    send_random_strings(20);
    wait_drained();
    send_random_strings(20);
  endtask

  // Hold the output off for a long stretch while input keeps coming, so
  // the encoder fills and stalls its input.
  task automatic test_output_backpressure();
    sink_hold_req = 1'b1;
    send_random_strings(50);
  endtask

  // Back-to-back traffic on both sides.
  task automatic test_no_idle_stretch();
    calm = 1'b1;
    send_random_strings(80);
    calm = 1'b0;
  endtask

  task automatic test_random_text();
    while (bytes_sent < ITEM_TARGET) begin
      build_random_string();
      send_utf8_buf();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_passthrough_and_escapes();
    test_malformed_input();
    test_pause_until_drained();
    test_output_backpressure();
    test_no_idle_stretch();
    test_random_text();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    // Anything still predicted counts against the run.
    mismatches += path_bytes_due.size();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
